@@ src/ghr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ghr_pkg
// Shared types and constants of the grid heat relaxation block.
// ----------------------------------------------------------------------------
package ghr_pkg;

  localparam int MAX_SIDE    = 128;
  localparam int VALUE_WIDTH = 32;
  localparam int CNT_W       = $clog2(MAX_SIDE);
  localparam int SIDE_W      = CNT_W + 1;
  localparam int ADDR_W      = $clog2(MAX_SIDE * MAX_SIDE);
  localparam int DEPTH       = MAX_SIDE * MAX_SIDE;
  localparam int NN_W        = ADDR_W + 1;
  localparam int ITER_W      = 20;
  localparam int ACC_W       = 31;
  localparam int DIV_W       = 40;
  localparam int DVS_W       = CNT_W;

  localparam logic [ITER_W-1:0] ITER_CAP = ITER_W'(1000000);

  localparam logic [2:0] REG_GRID_SIZE = 3'd0;
  localparam logic [2:0] REG_ACCURACY  = 3'd1;
  localparam logic [2:0] REG_MAX_ITER  = 3'd2;
  localparam logic [2:0] REG_CORNER_TL = 3'd3;
  localparam logic [2:0] REG_CORNER_TR = 3'd4;
  localparam logic [2:0] REG_CORNER_BL = 3'd5;
  localparam logic [2:0] REG_CORNER_BR = 3'd6;

  localparam logic OP_SOLVE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  typedef struct packed {
    logic              operation;
    logic [ADDR_W-1:0] cell_index;
  } in_word_t;

  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0] cell_value;
    logic [31:0]                   final_loss;
    logic [ITER_W-1:0]             iterations_done;
    logic                          converged;
  } out_word_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

endpackage

@@ src/ghr_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ghr_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module ghr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/ghr_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ghr_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ghr_div
  import ghr_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int CW = $clog2(DIV_W + 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [DIV_W-1:0] quo_r, quo_nxt;
  logic [DVS_W-1:0] rem_r, rem_nxt;
  logic [DVS_W-1:0] dvs_r, dvs_nxt;
  logic [DVS_W:0]   trial;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    trial    = {rem_r, quo_r[DIV_W-1]};
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(DIV_W);
      quo_nxt  = req.dividend;
      rem_nxt  = '0;
      dvs_nxt  = req.divisor;
    end else if (busy_r) begin
      // The partial remainder stays below the divisor, so the trial fits.
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = DVS_W'(trial - {1'b0, dvs_r});
        quo_nxt = {quo_r[DIV_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[DVS_W-1:0];
        quo_nxt = {quo_r[DIV_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

@@ src/grid_heat_relaxation.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_heat_relaxation
// Gauss-Seidel relaxation of a square heat grid held in one block RAM.
// ----------------------------------------------------------------------------
// Usage. Configuration is written through cfg_we/cfg_index/cfg_wdata; the
// user must do so only while the block is idle, as the block itself does
// not enforce this. An input word with operation solve builds the grid from
// the corner registers (edges interpolated, inner cells zero) and then sweeps
// it in row order until the largest change of a sweep is at most the accuracy
// or the sweep limit is reached. One output word follows each input word:
// for a solve it carries the loss, sweep count and converged flag; a read
// returns the addressed cell together with the figures of the last solve.
// A read captures the RAM data in ST_RD_CAP and loads the output register in
// ST_OUT. A solve builds each edge cell through the serial divider and writes
// each inner cell directly; each sweep step makes four RAM reads, forms the
// sum and waits on the 40-step serial divider that forms each mean.
// One word is in work at a time; in_ready is high only when no word is in
// work. A finished output word sits in the output register until out_ready;
// the block may take the next input word meanwhile but will not finish it
// until the register is free. Reset clears control state and the last-solve
// figures; the grid RAM is undefined until a solve writes it.
// ----------------------------------------------------------------------------
module grid_heat_relaxation
  import ghr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_word_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_word_t   out_data,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_RD_CAP = 4'd1;
  localparam logic [3:0] ST_INIT   = 4'd2;
  localparam logic [3:0] ST_IDIV   = 4'd3;
  localparam logic [3:0] ST_SELF   = 4'd4;
  localparam logic [3:0] ST_UP     = 4'd5;
  localparam logic [3:0] ST_DN     = 4'd6;
  localparam logic [3:0] ST_RT     = 4'd7;
  localparam logic [3:0] ST_SUM    = 4'd8;
  localparam logic [3:0] ST_MDIV   = 4'd9;
  localparam logic [3:0] ST_OUT    = 4'd10;

  localparam int VW = VALUE_WIDTH;

  // Configuration registers.
  logic [SIDE_W-1:0]    grid_size_r;
  logic [ACC_W-1:0]     accuracy_r;
  logic [ITER_W-1:0]    max_iter_r;
  logic signed [VW-1:0] tl_r, tr_r, bl_r, br_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_size_r <= SIDE_W'(128);
      accuracy_r  <= ACC_W'(66);
      max_iter_r  <= ITER_CAP;
      tl_r        <= VW'(655360);
      tr_r        <= VW'(1310720);
      bl_r        <= VW'(1966080);
      br_r        <= VW'(1310720);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GRID_SIZE: grid_size_r <= cfg_wdata[SIDE_W-1:0];
        REG_ACCURACY:  accuracy_r  <= cfg_wdata[ACC_W-1:0];
        REG_MAX_ITER:  max_iter_r  <= cfg_wdata[ITER_W-1:0];
        REG_CORNER_TL: tl_r        <= cfg_wdata[VW-1:0];
        REG_CORNER_TR: tr_r        <= cfg_wdata[VW-1:0];
        REG_CORNER_BL: bl_r        <= cfg_wdata[VW-1:0];
        REG_CORNER_BR: br_r        <= cfg_wdata[VW-1:0];
        default: ;
      endcase
    end
  end

  // Effective side length and sweep limit.
  logic [SIDE_W-1:0] n;
  logic [CNT_W-1:0]  n_m1;
  logic [NN_W-1:0]   nn;
  logic [ITER_W-1:0] lim;

  always_comb begin
    if (grid_size_r < SIDE_W'(2)) begin
      n = SIDE_W'(2);
    end else if (grid_size_r > SIDE_W'(MAX_SIDE)) begin
      n = SIDE_W'(MAX_SIDE);
    end else begin
      n = grid_size_r;
    end
    n_m1 = CNT_W'(n - SIDE_W'(1));
    nn   = NN_W'(n) * NN_W'(n);
    lim  = (max_iter_r > ITER_CAP) ? ITER_CAP : max_iter_r;
  end

  // Sequencer registers.
  logic [3:0]           st_r, st_nxt;
  logic                 op_r, op_nxt;
  logic                 in_range_r, in_range_nxt;
  logic [NN_W-1:0]      solved_nn_r, solved_nn_nxt;
  logic [ADDR_W-1:0]    i_r, i_nxt;
  logic [CNT_W-1:0]     row_r, row_nxt;
  logic [CNT_W-1:0]     col_r, col_nxt;
  logic [ITER_W-1:0]    it_r, it_nxt;
  logic [31:0]          worst_r, worst_nxt;
  logic signed [VW-1:0] self_r, self_nxt;
  logic signed [VW-1:0] up_r, up_nxt;
  logic signed [VW-1:0] dn_r, dn_nxt;
  logic signed [VW-1:0] left_r, left_nxt;
  logic signed [VW-1:0] base_r, base_nxt;
  logic signed [VW-1:0] cell_r, cell_nxt;
  logic                 neg_r, neg_nxt;

  logic [31:0]          last_loss_r, last_loss_nxt;
  logic [ITER_W-1:0]    last_iter_r, last_iter_nxt;
  logic                 last_conv_r, last_conv_nxt;

  logic                 out_valid_r, out_valid_nxt;
  out_word_t            out_data_r, out_data_nxt;

  // Memory and divider hookup.
  logic                 mem_we;
  logic [ADDR_W-1:0]    mem_raddr;
  logic [VW-1:0]        mem_wdata;
  logic [VW-1:0]        mem_rdata;
  div_req_t             div_req;
  div_rsp_t             div_rsp;

  ghr_ram #(
    .WIDTH (VW),
    .DEPTH (DEPTH)
  ) u_grid (
    .clk   (clk),
    .we    (mem_we),
    .waddr (i_r),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  ghr_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Position of the current cell.
  logic has_up, has_dn, has_lf, has_rt, last_cell;
  assign has_up    = (row_r != '0);
  assign has_dn    = (row_r != n_m1);
  assign has_lf    = (col_r != '0);
  assign has_rt    = (col_r != n_m1);
  assign last_cell = !has_dn && !has_rt;

  // Edge interpolation operands.
  logic signed [VW-1:0]   ea, eb;
  logic [CNT_W-1:0]       ek;
  logic                   is_edge;
  logic signed [VW:0]     ediff;
  logic signed [VW+CNT_W+1:0] eprod;
  logic [VW+CNT_W+1:0]    emag;

  always_comb begin
    is_edge = 1'b1;
    ea = tl_r;
    eb = tr_r;
    ek = col_r;
    priority if (!has_up) begin
      ea = tl_r; eb = tr_r; ek = col_r;
    end else if (!has_dn) begin
      ea = bl_r; eb = br_r; ek = col_r;
    end else if (!has_lf) begin
      ea = tl_r; eb = bl_r; ek = row_r;
    end else if (!has_rt) begin
      ea = tr_r; eb = br_r; ek = row_r;
    end else begin
      is_edge = 1'b0;
    end
    ediff = (VW+1)'(eb) - (VW+1)'(ea);
    eprod = (VW+CNT_W+2)'(ediff) * $signed({2'b00, ek});
    emag  = eprod[VW+CNT_W+1] ? (VW+CNT_W+2)'(-eprod) : (VW+CNT_W+2)'(eprod);
  end

  // Neighbor sum for the mean; the right neighbor arrives from the RAM in ST_SUM.
  logic signed [VW+2:0] sum;
  logic [2:0]           cnt;
  logic [VW+2:0]        smag;
  logic [VW+3:0]        mmag;

  always_comb begin
    sum = (VW+3)'(self_r);
    cnt = 3'd1;
    if (has_up) begin
      sum = sum + (VW+3)'(up_r);
      cnt = cnt + 3'd1;
    end
    if (has_dn) begin
      sum = sum + (VW+3)'(dn_r);
      cnt = cnt + 3'd1;
    end
    if (has_lf) begin
      sum = sum + (VW+3)'(left_r);
      cnt = cnt + 3'd1;
    end
    if (has_rt) begin
      sum = sum + (VW+3)'($signed(mem_rdata));
      cnt = cnt + 3'd1;
    end
    smag = sum[VW+2] ? (VW+3)'(-sum) : (VW+3)'(sum);
    // Adding half the count makes the truncating divide round half away.
    mmag = (VW+4)'(smag) + (VW+4)'(cnt >> 1);
  end

  // Results of the divider.
  logic signed [VW+1:0] qs;
  logic signed [VW+1:0] lerp_val;
  logic signed [VW:0]   avg;
  logic signed [VW:0]   delta;
  logic [31:0]          dmag;

  always_comb begin
    qs       = $signed({2'b00, div_rsp.quotient[VW-1:0]});
    lerp_val = (VW+2)'(base_r) + (neg_r ? -qs : qs);
    avg      = (VW+1)'(neg_r ? -qs : qs);
    delta    = avg - (VW+1)'(self_r);
    dmag     = delta[VW] ? 32'(-delta) : 32'(delta);
  end

  always_comb begin
    st_nxt        = st_r;
    op_nxt        = op_r;
    in_range_nxt  = in_range_r;
    solved_nn_nxt = solved_nn_r;
    i_nxt         = i_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    it_nxt        = it_r;
    worst_nxt     = worst_r;
    self_nxt      = self_r;
    up_nxt        = up_r;
    dn_nxt        = dn_r;
    left_nxt      = left_r;
    base_nxt      = base_r;
    cell_nxt      = cell_r;
    neg_nxt       = neg_r;
    last_loss_nxt = last_loss_r;
    last_iter_nxt = last_iter_r;
    last_conv_nxt = last_conv_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    mem_we        = 1'b0;
    mem_wdata     = '0;
    mem_raddr     = i_r;
    div_req       = '0;
    in_ready      = (st_r == ST_IDLE);

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (st_r)
      ST_IDLE: begin
        mem_raddr = in_data.cell_index;
        if (in_valid) begin
          op_nxt       = in_data.operation;
          // Cells past the current grid or past the last solve's grid read as zero.
          in_range_nxt = (NN_W'(in_data.cell_index) < nn)
                         && (NN_W'(in_data.cell_index) < solved_nn_r);
          if (in_data.operation == OP_SOLVE) begin
            solved_nn_nxt = nn;
          end
          i_nxt        = '0;
          row_nxt      = '0;
          col_nxt      = '0;
          st_nxt       = (in_data.operation == OP_READ) ? ST_RD_CAP : ST_INIT;
        end
      end
      ST_RD_CAP: begin
        cell_nxt = in_range_r ? $signed(mem_rdata) : '0;
        st_nxt   = ST_OUT;
      end
      ST_INIT: begin
        if (is_edge) begin
          div_req.start    = 1'b1;
          div_req.dividend = DIV_W'(emag);
          div_req.divisor  = n_m1;
          base_nxt         = ea;
          neg_nxt          = eprod[VW+CNT_W+1];
          st_nxt           = ST_IDIV;
        end else begin
          mem_we = 1'b1;
          // Inner cells start at zero; go straight to the next cell.
          i_nxt   = i_r + ADDR_W'(1);
          col_nxt = col_r + CNT_W'(1);
        end
      end
      ST_IDIV: begin
        if (div_rsp.done) begin
          mem_we    = 1'b1;
          mem_wdata = lerp_val[VW-1:0];
          if (last_cell) begin
            i_nxt     = '0;
            row_nxt   = '0;
            col_nxt   = '0;
            worst_nxt = '0;
            it_nxt    = ITER_W'(1);
            if (lim == '0) begin
              last_loss_nxt = '0;
              last_iter_nxt = ITER_W'(1);
              last_conv_nxt = 1'b0;
              cell_nxt      = '0;
              st_nxt        = ST_OUT;
            end else begin
              st_nxt = ST_SELF;
            end
          end else begin
            i_nxt = i_r + ADDR_W'(1);
            if (!has_rt) begin
              col_nxt = '0;
              row_nxt = row_r + CNT_W'(1);
            end else begin
              col_nxt = col_r + CNT_W'(1);
            end
            st_nxt = ST_INIT;
          end
        end
      end
      ST_SELF: begin
        mem_raddr = i_r;
        st_nxt    = ST_UP;
      end
      ST_UP: begin
        self_nxt  = $signed(mem_rdata);
        mem_raddr = i_r - ADDR_W'(n);
        st_nxt    = ST_DN;
      end
      ST_DN: begin
        up_nxt    = $signed(mem_rdata);
        mem_raddr = i_r + ADDR_W'(n);
        st_nxt    = ST_RT;
      end
      ST_RT: begin
        dn_nxt    = $signed(mem_rdata);
        mem_raddr = i_r + ADDR_W'(1);
        st_nxt    = ST_SUM;
      end
      ST_SUM: begin
        div_req.start    = 1'b1;
        div_req.dividend = DIV_W'(mmag);
        div_req.divisor  = DVS_W'(cnt);
        neg_nxt          = sum[VW+2];
        st_nxt           = ST_MDIV;
      end
      ST_MDIV: begin
        if (div_rsp.done) begin
          mem_we    = 1'b1;
          mem_wdata = avg[VW-1:0];
          left_nxt  = avg[VW-1:0];
          worst_nxt = (dmag > worst_r) ? dmag : worst_r;
          if (last_cell) begin
            i_nxt   = '0;
            row_nxt = '0;
            col_nxt = '0;
            if (worst_nxt <= 32'(accuracy_r)) begin
              last_loss_nxt = worst_nxt;
              last_iter_nxt = it_r;
              last_conv_nxt = 1'b1;
              cell_nxt      = '0;
              st_nxt        = ST_OUT;
            end else if (it_r == lim) begin
              last_loss_nxt = worst_nxt;
              last_iter_nxt = it_r + ITER_W'(1);
              last_conv_nxt = 1'b0;
              cell_nxt      = '0;
              st_nxt        = ST_OUT;
            end else begin
              it_nxt    = it_r + ITER_W'(1);
              worst_nxt = '0;
              st_nxt    = ST_SELF;
            end
          end else begin
            i_nxt = i_r + ADDR_W'(1);
            if (!has_rt) begin
              col_nxt = '0;
              row_nxt = row_r + CNT_W'(1);
            end else begin
              col_nxt = col_r + CNT_W'(1);
            end
            st_nxt = ST_SELF;
          end
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt                = 1'b1;
          out_data_nxt.cell_value      = cell_r;
          out_data_nxt.final_loss      = last_loss_r;
          out_data_nxt.iterations_done = last_iter_r;
          out_data_nxt.converged       = last_conv_r;
          st_nxt                       = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      out_valid_r <= 1'b0;
      last_loss_r <= '0;
      last_iter_r <= '0;
      last_conv_r <= 1'b0;
      solved_nn_r <= '0;
    end else begin
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
      last_loss_r <= last_loss_nxt;
      last_iter_r <= last_iter_nxt;
      last_conv_r <= last_conv_nxt;
      solved_nn_r <= solved_nn_nxt;
    end
    op_r       <= op_nxt;
    in_range_r <= in_range_nxt;
    i_r        <= i_nxt;
    row_r      <= row_nxt;
    col_r      <= col_nxt;
    it_r       <= it_nxt;
    worst_r    <= worst_nxt;
    self_r     <= self_nxt;
    up_r       <= up_nxt;
    dn_r       <= dn_nxt;
    left_r     <= left_nxt;
    base_r     <= base_nxt;
    cell_r     <= cell_nxt;
    neg_r      <= neg_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Writes never leave the grid in use.
  a_write_in_grid : assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (NN_W'(i_r) < nn))
    else $error("grid write outside the active grid");

  // A converged solve reports a loss within the accuracy.
  a_conv_loss : assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_OUT && op_r == OP_SOLVE && last_conv_r)
      |-> (last_loss_r <= 32'(accuracy_r)))
    else $error("converged solve with loss above accuracy");

  // A solve that gave up reports one more than the limit.
  a_giveup_count : assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_OUT && op_r == OP_SOLVE && !last_conv_r)
      |-> (last_iter_r == lim + ITER_W'(1)))
    else $error("unconverged solve with wrong sweep count");

  // The divider answers only while a step waits for it.
  a_div_owner : assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (st_r == ST_IDIV || st_r == ST_MDIV))
    else $error("divider result with no waiting step");

endmodule

@@ sim/grid_heat_relaxation_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_heat_relaxation_tb
// Self-checking bench for the Gauss-Seidel heat grid solver. A directed part
// covers corner extremes, size and sweep-limit clamping, zero sweep limit,
// reads outside the grid and reads after a size change. A random part
// follows with small grids. Every output word is checked against a local
// predictor of the relaxation.
// ----------------------------------------------------------------------------
module grid_heat_relaxation_tb;
  import ghr_pkg::*;

  localparam int CYCLE_LIMIT = 4000000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_word_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_word_t   out_data;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = REG_GRID_SIZE;
  logic [31:0] cfg_wdata = '0;

  grid_heat_relaxation i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #6 clk = ~clk;

  // Register copies and solver state of the predictor.
  logic [7:0]  sz_reg = 8'd128;
  logic [30:0] acc_reg = 31'd66;
  logic [19:0] iter_reg = 20'd1000000;
  longint      corner_tl = 655360, corner_tr = 1310720;
  longint      corner_bl = 1966080, corner_br = 1310720;
  longint      grid_img [0:DEPTH-1];
  logic [31:0] solve_loss = '0;
  logic [19:0] solve_iters = '0;
  logic        solve_conv = 1'b0;

  in_word_t  pending_words [$];
  out_word_t expected_words [$];
  int        errors = 0;
  int        accepted = 0;
  int        results_seen = 0;
  int        cycles = 0;
  logic      in_took = 1'b0;
  logic      send_hold = 1'b0;
  int        stall_left = 0;
  logic      stall_done = 1'b0;
  int        gen_nn = 0;

  function automatic longint side_now();
    if (sz_reg < 2) return 2;
    if (sz_reg > MAX_SIDE) return MAX_SIDE;
    return sz_reg;
  endfunction

  function automatic longint edge_value(longint a, longint b, longint k, longint span);
    return a + ((b - a) * k) / span;
  endfunction

  function automatic longint mean_round(longint s, longint c);
    longint m, q;
    m = (s < 0) ? -s : s;
    q = (m + c / 2) / c;
    return (s < 0) ? -q : q;
  endfunction

  function automatic void relax_grid();
    longint n, nn, lim, it, worst, loss, old, s, c, avg, d, i, k;
    logic conv;
    n = side_now();
    nn = n * n;
    lim = (iter_reg > ITER_CAP) ? ITER_CAP : iter_reg;
    loss = 0;
    conv = 1'b0;
    for (i = 0; i < DEPTH; i++) grid_img[i] = 0;
    grid_img[0] = corner_tl;
    grid_img[n - 1] = corner_tr;
    grid_img[n * (n - 1)] = corner_bl;
    grid_img[nn - 1] = corner_br;
    for (k = 1; k < n - 1; k++) begin
      grid_img[k] = edge_value(corner_tl, corner_tr, k, n - 1);
      grid_img[n * (n - 1) + k] = edge_value(corner_bl, corner_br, k, n - 1);
      grid_img[n * k] = edge_value(corner_tl, corner_bl, k, n - 1);
      grid_img[n * (k + 1) - 1] = edge_value(corner_tr, corner_br, k, n - 1);
    end
    for (it = 1; it <= lim; it++) begin
      worst = 0;
      for (i = 0; i < nn; i++) begin
        old = grid_img[i];
        s = old;
        c = 1;
        if (i >= n) begin s += grid_img[i - n]; c++; end
        if (i + n < nn) begin s += grid_img[i + n]; c++; end
        if (i % n != 0) begin s += grid_img[i - 1]; c++; end
        if (i % n != n - 1) begin s += grid_img[i + 1]; c++; end
        avg = mean_round(s, c);
        d = (avg > old) ? avg - old : old - avg;
        if (d > worst) worst = d;
        grid_img[i] = avg;
      end
      loss = worst;
      if (longint'(acc_reg) >= loss) begin
        conv = 1'b1;
        break;
      end
    end
    solve_loss = (loss > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : loss[31:0];
    solve_iters = it[19:0];
    solve_conv = conv;
  endfunction

  function automatic out_word_t predict_word(in_word_t w);
    out_word_t r;
    longint nn;
    nn = side_now() * side_now();
    r.cell_value = '0;
    if (w.operation == OP_SOLVE) relax_grid();
    else if (longint'(w.cell_index) < nn) r.cell_value = grid_img[w.cell_index][31:0];
    r.final_loss = solve_loss;
    r.iterations_done = solve_iters;
    r.converged = solve_conv;
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
    errors++;
  endtask

  // Acceptance, prediction and checking, all on the rising edge.
  always @(posedge clk) begin
    out_word_t e;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("grid_heat_relaxation_tb: FAIL");
      $finish;
    end
    in_took <= rst_n && in_valid && in_ready;
    if (rst_n && in_valid && in_ready) begin
      expected_words.push_back(predict_word(in_data));
      accepted <= accepted + 1;
    end
    if (rst_n && out_valid && out_ready) begin
      results_seen <= results_seen + 1;
      if (expected_words.size() == 0) begin
        report_mismatch("unexpected word", longint'(out_data.cell_value), 0);
      end else begin
        e = expected_words.pop_front();
        if (out_data.cell_value !== e.cell_value)
          report_mismatch("cell_value", out_data.cell_value, e.cell_value);
        if (out_data.final_loss !== e.final_loss)
          report_mismatch("final_loss", out_data.final_loss, e.final_loss);
        if (out_data.iterations_done !== e.iterations_done)
          report_mismatch("iterations_done", out_data.iterations_done, e.iterations_done);
        if (out_data.converged !== e.converged)
          report_mismatch("converged", out_data.converged, e.converged);
      end
    end
  end

  // Input driver. Idling is switched off for a stretch of accepted words.
  always @(negedge clk) begin
    logic quiet;
    quiet = (accepted >= 45 && accepted < 70);
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_took) begin
      in_valid <= 1'b1;
    end else if (pending_words.size() > 0 && !send_hold
                 && (quiet || $urandom_range(0, 99) >= 17)) begin
      in_data <= pending_words.pop_front();
      in_valid <= 1'b1;
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Output ready, with one long hold-off after thirty words.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if (results_seen == 30 && !stall_done) begin
      stall_left <= 400;
      stall_done <= 1'b1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= (accepted >= 45 && accepted < 70) || ($urandom_range(0, 99) >= 17);
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    case (idx)
      REG_GRID_SIZE: sz_reg = value[7:0];
      REG_ACCURACY:  acc_reg = value[30:0];
      REG_MAX_ITER:  iter_reg = value[19:0];
      REG_CORNER_TL: corner_tl = longint'(signed'(value));
      REG_CORNER_TR: corner_tr = longint'(signed'(value));
      REG_CORNER_BL: corner_bl = longint'(signed'(value));
      REG_CORNER_BR: corner_br = longint'(signed'(value));
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_idle();
    while (pending_words.size() > 0 || in_valid || expected_words.size() > 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic queue_solve();
    in_word_t w;
    w.operation = OP_SOLVE;
    w.cell_index = ADDR_W'($urandom);
    pending_words.push_back(w);
    gen_nn = side_now() * side_now();
  endtask

  task automatic queue_read(int idx);
    in_word_t w;
    w.operation = OP_READ;
    w.cell_index = idx[ADDR_W-1:0];
    pending_words.push_back(w);
  endtask

  // Random read: inside the current grid once a solve is queued, or outside it.
  task automatic queue_random_read();
    int nn, lim;
    nn = side_now() * side_now();
    lim = (gen_nn == 0) ? 0 : nn;
    if (nn < DEPTH && (lim == 0 || $urandom_range(0, 3) == 0))
      queue_read($urandom_range(nn, DEPTH - 1));
    else if (lim > 0)
      queue_read($urandom_range(0, lim - 1));
  endtask

  initial begin
    int n;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Extreme corners on the smallest grid; sweep limit above the cap.
    write_reg(REG_GRID_SIZE, 32'd2);
    write_reg(REG_ACCURACY, 32'h7FFF_FFFF);
    write_reg(REG_MAX_ITER, 32'hF_FFFF);
    write_reg(REG_CORNER_TL, 32'h7FFF_FFFF);
    write_reg(REG_CORNER_TR, 32'h8000_0000);
    write_reg(REG_CORNER_BL, 32'h0000_0000);
    write_reg(REG_CORNER_BR, 32'hFFFF_FFFF);
    queue_read(DEPTH - 1);
    queue_read(4);
    queue_solve();
    for (int i = 0; i < 4; i++) queue_read(i);
    queue_read(DEPTH - 1);
    wait_idle();

    // Size below range and a zero sweep limit, then a single sweep.
    write_reg(REG_GRID_SIZE, 32'd0);
    write_reg(REG_ACCURACY, 32'd0);
    write_reg(REG_MAX_ITER, 32'd0);
    queue_solve();
    queue_read(0);
    queue_read(3);
    wait_idle();
    write_reg(REG_MAX_ITER, 32'd1);
    queue_solve();
    queue_read(1);
    queue_read(2);
    wait_idle();

    // Size above range: the largest grid is only built, never swept.
    write_reg(REG_GRID_SIZE, 32'd255);
    write_reg(REG_MAX_ITER, 32'd0);
    write_reg(REG_CORNER_TL, 32'h8000_0000);
    write_reg(REG_CORNER_BR, 32'h7FFF_FFFF);
    queue_solve();
    queue_read(0);
    queue_read(127);
    queue_read(16256);
    queue_read(DEPTH - 1);
    queue_read(8000);
    wait_idle();

    // Normal solve, then the grid shrinks and old cells are read.
    write_reg(REG_GRID_SIZE, 32'd4);
    write_reg(REG_ACCURACY, 32'd66);
    write_reg(REG_MAX_ITER, 32'd10);
    write_reg(REG_CORNER_TL, 32'd655360);
    write_reg(REG_CORNER_BR, 32'd1310720);
    queue_solve();
    queue_read(5);
    wait_idle();
    write_reg(REG_GRID_SIZE, 32'd3);
    queue_read(8);
    queue_read(9);
    queue_read(4);
    wait_idle();

    // Random phases with small grids.
    for (int ph = 0; ph < 6; ph++) begin
      n = ($urandom_range(0, 4) == 0) ? $urandom_range(6, 8) : $urandom_range(2, 4);
      write_reg(REG_GRID_SIZE, n);
      case ($urandom_range(0, 2))
        0: write_reg(REG_ACCURACY, 32'd0);
        1: write_reg(REG_ACCURACY, $urandom_range(0, 200000));
        default: write_reg(REG_ACCURACY, {1'b0, 31'($urandom)});
      endcase
      write_reg(REG_MAX_ITER, (n > 4) ? $urandom_range(0, 4) : $urandom_range(0, 12));
      write_reg(REG_CORNER_TL, $urandom);
      write_reg(REG_CORNER_TR, $urandom);
      write_reg(REG_CORNER_BL, $urandom);
      write_reg(REG_CORNER_BR, $urandom);
      for (int j = 0; j < 13; j++) begin
        if ($urandom_range(0, 3) == 0 || gen_nn == 0) queue_solve();
        else queue_random_read();
        // Midway through one phase the sender waits for every result.
        if (ph == 2 && j == 8) begin
          send_hold = 1'b0;
          wait_idle();
        end
      end
      wait_idle();
    end

    wait_idle();
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("grid_heat_relaxation_tb: PASS");
    end else begin
      $display("grid_heat_relaxation_tb: FAIL");
    end
    $finish;
  end

endmodule
